>>> design/mqup_pkg.sv
package mqup_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int MSG_W     = 8;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [MSG_W-1:0] FREE_MARKER_RST = '0;

    // register index taken from the word address
    localparam logic REG_FREE_MARKER = 1'b0;

    typedef enum logic [1:0] {
        ACT_SEND   = 2'd0,
        ACT_URGENT = 2'd1,
        ACT_GET    = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef struct packed {
        logic             valid;
        action_t          action;
        logic [MSG_W-1:0] msg;
    } cmd_t;

    typedef struct packed {
        logic             status;
        logic [MSG_W-1:0] msg;
    } res_t;

endpackage

>>> design/mqup_cfg.sv
module mqup_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mqup_pkg::ADDR_W-1:0]  paddr,
    input  logic [mqup_pkg::DATA_W-1:0]  pwdata,
    output logic [mqup_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [mqup_pkg::MSG_W-1:0]   marker
);
    import mqup_pkg::*;

    logic [MSG_W-1:0] marker_reg;
    logic [MSG_W-1:0] marker_next;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1];
    assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_FREE_MARKER);

    always_comb
    begin
        marker_next = marker_reg;
        if (wr_en)
        begin
            marker_next = pwdata[MSG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= FREE_MARKER_RST;
        end
        else
        begin
            marker_reg <= marker_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_FREE_MARKER)
        begin
            prdata = {{(DATA_W-MSG_W){1'b0}}, marker_reg};
        end
    end

    assign marker = marker_reg;

endmodule

>>> design/mqup_row.sv
module mqup_row #(
    parameter int DEPTH = mqup_pkg::DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [mqup_pkg::MSG_W-1:0] marker,
    input  mqup_pkg::cmd_t             exec,
    output mqup_pkg::res_t             res
);
    import mqup_pkg::*;

    logic [MSG_W-1:0] slots_reg  [DEPTH];
    logic [MSG_W-1:0] slots_next [DEPTH];
    logic [DEPTH-1:0] free_vec;
    logic [DEPTH-1:0] first_free;
    logic             any_free;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            free_vec[i] = (slots_reg[i] == marker);
        end
    end

    // priority pick of the lowest free slot
    always_comb
    begin
        any_free = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            first_free[i] = free_vec[i] && !any_free;
            any_free      = any_free || free_vec[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slots_next[i] = slots_reg[i];
        end
        res.status = 1'b0;
        res.msg    = marker;
        case (exec.action)
            ACT_SEND:
            begin
                res.status = !any_free;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (first_free[i])
                    begin
                        slots_next[i] = exec.msg;
                    end
                end
            end
            ACT_URGENT:
            begin
                for (int i = 1; i < DEPTH; i++)
                begin
                    slots_next[i] = slots_reg[i-1];
                end
                slots_next[0] = exec.msg;
            end
            ACT_GET:
            begin
                res.msg = slots_reg[0];
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    slots_next[i] = slots_reg[i+1];
                end
                slots_next[DEPTH-1] = marker;
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    slots_next[i] = marker;
                end
            end
            default:
            begin
                res.status = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                slots_reg[i] <= FREE_MARKER_RST;
            end
        end
        else if (exec.valid)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                slots_reg[i] <= slots_next[i];
            end
        end
    end

    a_clear_frees_all: assert property (@(posedge clk) disable iff (!rst_n)
        exec.valid && exec.action == ACT_CLEAR |=> (&free_vec) || !$stable(marker))
        else $error("clear left a slot occupied");

    a_full_send_keeps_row: assert property (@(posedge clk) disable iff (!rst_n)
        exec.valid && exec.action == ACT_SEND && !any_free && $stable(marker)
        |=> free_vec == '0 || !$stable(marker))
        else $error("rejected send changed the row");

    a_urgent_fills_front: assert property (@(posedge clk) disable iff (!rst_n)
        exec.valid && exec.action == ACT_URGENT |=> slots_reg[0] == $past(exec.msg))
        else $error("urgent send did not land at the front");

endmodule

>>> design/message_queue_with_urgent_push_top.sv
// An accepted input beat waits in the input register until the result register is free
// or draining, then loads it; m_tvalid offers the result beat until it is taken.
// Throughput: one beat per cycle unless m_tready stalls; the input register feeds the
// slot row and the result register in the same cycle, so nothing iterates.
// Reset (rst_n, async, active low): all slots and the free marker go to zero,
// both pipeline registers empty.
module message_queue_with_urgent_push_top #(
    parameter int DEPTH = mqup_pkg::DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [1:0] action, [9:2] msg_in
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [0] status, [8:1] msg_out
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mqup_pkg::ADDR_W-1:0]  paddr,
    input  logic [mqup_pkg::DATA_W-1:0]  pwdata,
    output logic [mqup_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import mqup_pkg::*;

    logic             in_valid_reg;
    logic             in_valid_next;
    action_t          in_action_reg;
    logic [MSG_W-1:0] in_msg_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    res_t             out_res_reg;
    logic             advance;
    logic             in_take;
    logic [MSG_W-1:0] marker;
    cmd_t             exec;
    res_t             res;

    mqup_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .marker  (marker)
    );

    // advance the held beat when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign exec.valid  = advance;
    assign exec.action = in_action_reg;
    assign exec.msg    = in_msg_reg;

    mqup_row #(
        .DEPTH (DEPTH)
    ) u_row (
        .clk    (clk),
        .rst_n  (rst_n),
        .marker (marker),
        .exec   (exec),
        .res    (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_action_reg <= action_t'(s_tdata[1:0]);
            in_msg_reg    <= s_tdata[MSG_W+1:2];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-MSG_W-1){1'b0}}, out_res_reg.msg, out_res_reg.status};

    a_no_beat_from_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg && !out_valid_reg |=> !out_valid_reg)
        else $error("result beat appeared without an input beat");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while both stages are stalled");

    a_held_beat_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("held beat did not reach the result register");

endmodule
